[hw/rtl/quadrature_detent_event_queue_macros.svh]
// Assertion macros shared by the detent event queue RTL.
// Every macro samples on the rising edge of clk and is switched off during rst.
`ifndef QUADRATURE_DETENT_EVENT_QUEUE_MACROS_SVH
`define QUADRATURE_DETENT_EVENT_QUEUE_MACROS_SVH

// The condition holds at every clock edge.
`define QDEQ_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define QDEQ_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define QDEQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/qdeq_pkg.sv]
// Shared constants, types and helper functions of the detent event queue.
// Used by qdeq_step and quadrature_detent_event_queue; depends on nothing.
package qdeq_pkg;

  localparam int NUM_ENCODERS = 8;
  localparam int QUEUE_DEPTH  = 16;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int ENC_W    = 3;
  localparam int AB_W     = 2;
  localparam int TICK_W   = 32;
  localparam int SERIAL_W = 32;
  localparam int DIR_W    = 2;
  localparam int PEND_W   = 5;
  localparam int DROP_W   = 32;
  localparam int TPD_W    = 3;
  localparam int RES_W    = 3;
  localparam int CNT_W    = 3;

  // Derived storage widths.
  localparam int ENC_AW    = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int PTR_W     = $clog2(2 * QUEUE_DEPTH);
  localparam int ENC_MEM_W = AB_W + RES_W;
  localparam int Q_MEM_W   = TICK_W + SERIAL_W + ENC_W + 1;

  // Stream payload widths.
  localparam int S_FIELDS_W = ENC_W + AB_W + TICK_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = ENC_W + DIR_W + TICK_W + SERIAL_W + PEND_W + DROP_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;
  localparam logic [OP_W-1:0] OP_SEED    = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TPD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REV = 1'd1;
  localparam logic [TPD_W-1:0] TPD_RESET = 3'd4;

  // Direction codes on the result.
  localparam logic [DIR_W-1:0] DIR_POS = 2'b01;
  localparam logic [DIR_W-1:0] DIR_NEG = 2'b11;

  // Quadrature step per {previous, current} pin state, as two-bit signed codes.
  localparam logic [1:0] QUAD_STEPS [0:15] = '{
    2'b00, 2'b11, 2'b01, 2'b00,
    2'b01, 2'b00, 2'b00, 2'b11,
    2'b11, 2'b00, 2'b00, 2'b01,
    2'b00, 2'b01, 2'b11, 2'b00
  };

  // Decoded outcome of one sample.
  typedef struct packed {
    logic             changed;
    logic [RES_W-1:0] res;
    logic [CNT_W-1:0] count;
    logic             neg;
  } step_t;

  // Queue pointers run modulo twice the depth.
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(2 * QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    if (p >= PTR_W'(QUEUE_DEPTH)) begin
      return SLOT_W'(p - PTR_W'(QUEUE_DEPTH));
    end
    return SLOT_W'(p);
  endfunction

  function automatic logic [PEND_W-1:0] pend(input logic [PTR_W-1:0] wp,
                                             input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] d;
    if (wp >= rp) begin
      d = {1'b0, wp} - {1'b0, rp};
    end else begin
      d = {1'b0, wp} + (PTR_W + 1)'(2 * QUEUE_DEPTH) - {1'b0, rp};
    end
    return PEND_W'(d);
  endfunction

endpackage

[hw/rtl/qdeq_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read.
// Stands alone; used for the encoder state and the event queue storage.
module qdeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/qdeq_step.sv]
// Quadrature step decoder: table lookup, direction, residual and detent count.
// Depends on qdeq_pkg for the step table and the step_t result type.
module qdeq_step (
  input  logic [qdeq_pkg::AB_W-1:0]  prev,
  input  logic [qdeq_pkg::AB_W-1:0]  ab,
  input  logic [qdeq_pkg::RES_W-1:0] res,
  input  logic [qdeq_pkg::TPD_W-1:0] tpd,
  input  logic                       rev,
  output qdeq_pkg::step_t            result
);

  logic [1:0] step_raw;
  logic [1:0] stp;
  logic [3:0] total;
  logic [3:0] tot_abs;
  logic [2:0] mag;
  logic [qdeq_pkg::CNT_W-1:0] q;
  logic [1:0] r;
  logic [2:0] rn;
  logic [qdeq_pkg::RES_W-1:0] res_div;
  logic nz;

  assign step_raw = qdeq_pkg::QUAD_STEPS[{prev, ab}];
  assign stp      = rev ? 2'(-step_raw) : step_raw;
  assign nz       = (stp != 2'b00);
  assign total    = {res[2], res} + {{2{stp[1]}}, stp};
  assign tot_abs  = total[3] ? 4'(-total) : total;
  assign mag      = tot_abs[2:0];

  // Truncating division of a magnitude of at most four by the clamped detent size.
  always_comb begin
    case (tpd) inside
      3'd0, 3'd1: begin
        q = mag;
        r = 2'd0;
      end
      3'd2: begin
        q = {1'b0, mag[2:1]};
        r = {1'b0, mag[0]};
      end
      3'd3: begin
        if (mag >= 3'd3) begin
          q = 3'd1;
          r = 2'(mag - 3'd3);
        end else begin
          q = 3'd0;
          r = mag[1:0];
        end
      end
      default: begin
        q = {2'b00, mag[2]};
        r = mag[1:0];
      end
    endcase
  end

  assign rn      = {1'b0, r};
  assign res_div = total[3] ? 3'(-rn) : rn;

  assign result.changed = (prev != ab);
  assign result.res     = nz ? res_div : res;
  assign result.count   = nz ? q : '0;
  assign result.neg     = total[3];

endmodule

[hw/rtl/quadrature_detent_event_queue.sv]
// Each request is taken in IDLE while the encoder and queue RAMs are read; EXEC acts on the
// registered read data, PUB writes one queue entry per detent published, and FIN holds the
// result until the output register is free. A new request is taken only once the last one
// has finished. Reset (rst, synchronous) empties the queue, zeroes all counters and encoder
// state, and restores the detent size to 4 and forward direction.
`include "quadrature_detent_event_queue_macros.svh"

module quadrature_detent_event_queue (
  input  logic                                clk,
  input  logic                                rst,
  // Request stream.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // s_tdata: encoder_index [2:0], ab_state [4:3], time_tick [36:5], zero above.
  input  logic [qdeq_pkg::S_TDATA_W-1:0]      s_tdata,
  // s_tuser: op [1:0].
  input  logic [qdeq_pkg::OP_W-1:0]           s_tuser,
  // Result stream.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // m_tdata: event_encoder [2:0], event_direction [4:3], event_tick [36:5],
  // event_serial [68:37], pending_count [73:69], overflow_count [105:74], zero above.
  output logic [qdeq_pkg::M_TDATA_W-1:0]      m_tdata,
  // m_tuser: event_valid [0].
  output logic                                m_tuser,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qdeq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qdeq_pkg::TPD_W-1:0]          cfg_data
);

  // The sequencer: IDLE takes a request and starts the RAM reads, EXEC acts on the
  // read data, PUB writes one event per cycle, FIN waits for the output register.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_PUB  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Configuration registers.
  logic [qdeq_pkg::TPD_W-1:0] tpd;
  logic                       rev;

  // Captured request.
  logic [qdeq_pkg::OP_W-1:0]   op_q;
  logic [qdeq_pkg::ENC_W-1:0]  enc_q;
  logic [qdeq_pkg::AB_W-1:0]   ab_q;
  logic [qdeq_pkg::TICK_W-1:0] tick_q;

  // Queue control and counters.
  logic [qdeq_pkg::PTR_W-1:0]    wp;
  logic [qdeq_pkg::PTR_W-1:0]    rp;
  logic [qdeq_pkg::PTR_W-1:0]    rp_next;
  logic [qdeq_pkg::SERIAL_W-1:0] serial;
  logic [qdeq_pkg::DROP_W-1:0]   drops;
  logic [qdeq_pkg::CNT_W-1:0]    pub_left;
  logic                          pub_neg;

  // Per-encoder valid bits: an entry that is not valid reads as zero.
  logic [qdeq_pkg::NUM_ENCODERS-1:0] prev_ok;
  logic [qdeq_pkg::NUM_ENCODERS-1:0] res_ok;

  // Event held for a result that could not be sent at once.
  logic                          ev_valid;
  logic [qdeq_pkg::ENC_W-1:0]    ev_enc;
  logic                          ev_neg;
  logic [qdeq_pkg::TICK_W-1:0]   ev_tick;
  logic [qdeq_pkg::SERIAL_W-1:0] ev_serial;

  // RAM ports.
  logic                            enc_we;
  logic [qdeq_pkg::ENC_AW-1:0]     enc_a;
  logic [qdeq_pkg::ENC_AW-1:0]     enc_raddr;
  logic [qdeq_pkg::ENC_MEM_W-1:0]  enc_wdata;
  logic [qdeq_pkg::ENC_MEM_W-1:0]  enc_rdata;
  logic                            q_we;
  logic [qdeq_pkg::Q_MEM_W-1:0]    q_wdata;
  logic [qdeq_pkg::Q_MEM_W-1:0]    q_rdata;

  // Decoded data in EXEC.
  logic                          enc_ok;
  logic [qdeq_pkg::AB_W-1:0]     prev_rd;
  logic [qdeq_pkg::RES_W-1:0]    res_rd;
  qdeq_pkg::step_t               st;
  logic                          pop_hit;
  logic                          pub_start;
  logic                          q_full;
  logic [qdeq_pkg::SERIAL_W-1:0] serial_inc;

  // Result selection.
  logic                          out_free;
  logic                          out_load;
  logic                          o_valid;
  logic [qdeq_pkg::ENC_W-1:0]    o_enc;
  logic                          o_neg;
  logic [qdeq_pkg::TICK_W-1:0]   o_tick;
  logic [qdeq_pkg::SERIAL_W-1:0] o_serial;
  logic [qdeq_pkg::DIR_W-1:0]    o_dir;
  logic [qdeq_pkg::PEND_W-1:0]   pend_cur;
  logic [qdeq_pkg::PEND_W-1:0]   pend_out;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Encoder state RAM holds {previous AB, residual}. Every access of a request is
  // finished before the next request is taken, so a read never meets a write to
  // the same entry.
  assign enc_raddr = qdeq_pkg::ENC_AW'(s_tdata[qdeq_pkg::ENC_W-1:0]);
  assign enc_a     = qdeq_pkg::ENC_AW'(enc_q);

  qdeq_ram #(
    .WIDTH (qdeq_pkg::ENC_MEM_W),
    .DEPTH (qdeq_pkg::NUM_ENCODERS)
  ) u_enc_ram (
    .clk   (clk),
    .we    (enc_we),
    .waddr (enc_a),
    .wdata (enc_wdata),
    .raddr (enc_raddr),
    .rdata (enc_rdata)
  );

  // Event queue RAM holds {tick, serial, encoder, negative}. The read slot follows
  // the read pointer, so a pop finds its entry in the cycle after acceptance.
  assign q_wdata = {tick_q, serial_inc, enc_q, pub_neg};

  qdeq_ram #(
    .WIDTH (qdeq_pkg::Q_MEM_W),
    .DEPTH (qdeq_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (qdeq_pkg::ptr_slot(wp)),
    .wdata (q_wdata),
    .raddr (qdeq_pkg::ptr_slot(rp)),
    .rdata (q_rdata)
  );

  assign enc_ok  = (32'(enc_q) < qdeq_pkg::NUM_ENCODERS);
  assign prev_rd = prev_ok[enc_a] ? enc_rdata[qdeq_pkg::ENC_MEM_W-1:qdeq_pkg::RES_W]
                                  : '0;
  assign res_rd  = res_ok[enc_a] ? enc_rdata[qdeq_pkg::RES_W-1:0] : '0;

  qdeq_step u_step (
    .prev   (prev_rd),
    .ab     (ab_q),
    .res    (res_rd),
    .tpd    (tpd),
    .rev    (rev),
    .result (st)
  );

  assign pend_cur   = qdeq_pkg::pend(wp, rp);
  assign q_full     = (pend_cur >= qdeq_pkg::PEND_W'(qdeq_pkg::QUEUE_DEPTH));
  assign serial_inc = ((serial + 1'b1) == '0) ? qdeq_pkg::SERIAL_W'(1) : serial + 1'b1;
  assign pop_hit    = (op_q == qdeq_pkg::OP_POP) && (rp != wp);
  assign out_free   = !m_tvalid || m_tready;

  // Work of the EXEC cycle: encoder write back, read pointer move, start of publishing.
  always_comb begin
    enc_we    = 1'b0;
    enc_wdata = {ab_q, res_rd};
    rp_next   = rp;
    pub_start = 1'b0;
    if (state == ST_EXEC) begin
      unique case (op_q)
        qdeq_pkg::OP_SAMPLE: begin
          if (enc_ok && st.changed) begin
            enc_we    = 1'b1;
            enc_wdata = {ab_q, st.res};
            pub_start = (st.count != '0);
          end
        end
        qdeq_pkg::OP_POP: begin
          if (pop_hit) begin
            rp_next = qdeq_pkg::ptr_next(rp);
          end
        end
        qdeq_pkg::OP_DISCARD: begin
          rp_next = wp;
        end
        qdeq_pkg::OP_SEED: begin
          enc_we = enc_ok;
        end
        default: begin
          enc_we = 1'b0;
        end
      endcase
    end
  end

  // One event per PUB cycle; a full queue drops it but the serial still moves.
  assign q_we = (state == ST_PUB) && !q_full;

  // The result comes straight from EXEC when the output register is free, otherwise
  // from the hold registers in FIN.
  assign out_load = out_free &&
                    (((state == ST_EXEC) && !pub_start) || (state == ST_FIN));

  always_comb begin
    if (state == ST_EXEC) begin
      o_valid  = pop_hit;
      o_enc    = pop_hit ? q_rdata[qdeq_pkg::ENC_W:1] : '0;
      o_neg    = pop_hit && q_rdata[0];
      o_tick   = pop_hit ? q_rdata[qdeq_pkg::Q_MEM_W-1:qdeq_pkg::Q_MEM_W-qdeq_pkg::TICK_W]
                         : '0;
      o_serial = pop_hit ? q_rdata[qdeq_pkg::SERIAL_W+qdeq_pkg::ENC_W:qdeq_pkg::ENC_W+1]
                         : '0;
    end else begin
      o_valid  = ev_valid;
      o_enc    = ev_enc;
      o_neg    = ev_neg;
      o_tick   = ev_tick;
      o_serial = ev_serial;
    end
  end

  assign o_dir    = o_valid ? (o_neg ? qdeq_pkg::DIR_NEG : qdeq_pkg::DIR_POS) : '0;
  assign pend_out = qdeq_pkg::pend(wp, rp_next);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (pub_start) begin
          state_next = ST_PUB;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_PUB: begin
        if (pub_left == qdeq_pkg::CNT_W'(1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tpd      <= qdeq_pkg::TPD_RESET;
      rev      <= 1'b0;
      wp       <= '0;
      rp       <= '0;
      serial   <= '0;
      drops    <= '0;
      pub_left <= '0;
      prev_ok  <= '0;
      res_ok   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      rp    <= rp_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          qdeq_pkg::REG_TPD: tpd <= cfg_data;
          qdeq_pkg::REG_REV: rev <= cfg_data[0];
          default:           tpd <= tpd;
        endcase
      end

      if (enc_we) begin
        prev_ok[enc_a] <= 1'b1;
        res_ok[enc_a]  <= 1'b1;
      end
      if ((state == ST_EXEC) && (op_q == qdeq_pkg::OP_DISCARD)) begin
        res_ok <= '0;
      end

      if (pub_start) begin
        pub_left <= st.count;
      end else if (state == ST_PUB) begin
        pub_left <= pub_left - 1'b1;
        serial   <= serial_inc;
        if (q_full) begin
          drops <= drops + 1'b1;
        end else begin
          wp <= qdeq_pkg::ptr_next(wp);
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= s_tuser;
      enc_q  <= s_tdata[qdeq_pkg::ENC_W-1:0];
      ab_q   <= s_tdata[qdeq_pkg::ENC_W+qdeq_pkg::AB_W-1:qdeq_pkg::ENC_W];
      tick_q <= s_tdata[qdeq_pkg::S_FIELDS_W-1:qdeq_pkg::ENC_W+qdeq_pkg::AB_W];
    end
    if (pub_start) begin
      pub_neg <= st.neg;
    end
    if (state == ST_EXEC) begin
      ev_valid  <= o_valid;
      ev_enc    <= o_enc;
      ev_neg    <= o_neg;
      ev_tick   <= o_tick;
      ev_serial <= o_serial;
    end
    if (out_load) begin
      m_tuser <= o_valid;
      m_tdata <= {{qdeq_pkg::M_PAD_W{1'b0}}, drops, pend_out, o_serial, o_tick,
                  o_dir, o_enc};
    end
  end

  `QDEQ_ASSERT_ALWAYS(a_pend_bound, pend_cur <= qdeq_pkg::PEND_W'(qdeq_pkg::QUEUE_DEPTH), "pending count above queue depth")
  `QDEQ_ASSERT_SAME(a_no_write_full, q_we, !q_full, "queue written while full")
  `QDEQ_ASSERT_SAME(a_pub_nonzero, state == ST_PUB, pub_left != '0, "publishing with no detent left")
  `QDEQ_ASSERT_NEXT(a_serial_nonzero, state == ST_PUB, serial != '0, "event serial became zero")
  `QDEQ_ASSERT_NEXT(a_pop_advances, (state == ST_EXEC) && pop_hit, rp != $past(rp), "pop did not move the read pointer")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for quadrature_detent_event_queue: directed table, random traffic.
// Needs qdeq_pkg and the block's RTL; expected reports come from a decoder kept inside the bench.
module testbench;
  import qdeq_pkg::*;

  localparam int GAP_MAX       = 16;    // longest idle drawn per request or report
  localparam int LONG_HOLD     = 300;   // receiver back-pressure stretch, in cycles
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake before the run is abandoned
  localparam int DRAIN_SETTLE  = 8;     // settle after the last report before a register write
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 150;

  // One report as it travels on m_tdata / m_tuser, unpacked into named fields.
  typedef struct packed {
    logic                valid;
    logic [ENC_W-1:0]    enc;
    logic [DIR_W-1:0]    dir;
    logic [TICK_W-1:0]   tick;
    logic [SERIAL_W-1:0] serial;
    logic [PEND_W-1:0]   pending;
    logic [DROP_W-1:0]   overflow;
  } queue_report_t;

  typedef enum logic [1:0] {ROW_REQUEST, ROW_TYPED, ROW_REGISTER} row_kind_t;

  // A line of the directed table: a request, a request with its report written out,
  // or a register write.
  typedef struct {
    row_kind_t            kind;
    logic [OP_W-1:0]      op;
    logic [ENC_W-1:0]     enc;
    logic [AB_W-1:0]      ab;
    logic [TICK_W-1:0]    tick;
    queue_report_t        want;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [TPD_W-1:0]     reg_value;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [OP_W-1:0]      s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TPD_W-1:0]     cfg_data;

  quadrature_detent_event_queue dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the decoder: registers, per-encoder pin state and residual, and the event FIFO.
  // Pointers run modulo twice the depth so that a full queue differs from an empty one.
  logic [TPD_W-1:0]    detent_reg;
  logic                rev_reg;
  logic [AB_W-1:0]     last_ab     [NUM_ENCODERS];
  int                  residual    [NUM_ENCODERS];
  logic [ENC_W-1:0]    slot_enc    [QUEUE_DEPTH];
  logic                slot_neg    [QUEUE_DEPTH];
  logic [TICK_W-1:0]   slot_tick   [QUEUE_DEPTH];
  logic [SERIAL_W-1:0] slot_serial [QUEUE_DEPTH];
  int                  wr_ptr;
  int                  rd_ptr;
  logic [SERIAL_W-1:0] serial_ctr;
  logic [DROP_W-1:0]   drop_ctr;

  // Reports owed by the block, oldest first.
  queue_report_t owed_reports [$];

  int n_requests;
  int n_reports;
  int n_events;
  int n_reg_writes;
  int n_mismatch;
  int quiet_cycles;
  int gap_max_s;
  int gap_max_m;
  bit hold_reports;  // asks the report sink for one long back-pressure stretch
  bit offering;      // s_tvalid as last driven, visible before the NBA lands

  // Random phases: detent register value (0 and 5..7 are out of range on purpose), direction
  // register value (2 leaves bit 0 clear with bit 1 set), percentage of pops, and whether the
  // sender and the receiver idle between transfers.
  int phase_tpd   [RANDOM_PHASES] = '{1, 4, 2, 5, 3, 6, 0, 7, 4};
  int phase_rev   [RANDOM_PHASES] = '{0, 1, 0, 1, 0, 0, 1, 1, 2};
  int phase_pop   [RANDOM_PHASES] = '{15, 45, 60, 30, 50, 40, 10, 70, 35};
  int phase_s_gap [RANDOM_PHASES] = '{0, 1, 1, 1, 0, 1, 1, 0, 1};
  int phase_m_gap [RANDOM_PHASES] = '{1, 0, 1, 1, 1, 0, 1, 1, 1};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gray order of a forward-turning encoder: 0, 2, 3, 1, then back to 0.
  function automatic logic [AB_W-1:0] cw_next(logic [AB_W-1:0] s);
    case (s)
      2'd0: return 2'd2;
      2'd2: return 2'd3;
      2'd3: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [AB_W-1:0] ccw_next(logic [AB_W-1:0] s);
    case (s)
      2'd0: return 2'd1;
      2'd1: return 2'd3;
      2'd3: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic int queued_events();
    int d;
    d = (wr_ptr - rd_ptr + 2 * QUEUE_DEPTH) % (2 * QUEUE_DEPTH);
    return (d > QUEUE_DEPTH) ? QUEUE_DEPTH : d;
  endfunction

  // Applies one accepted request to the shadow state and returns the report it must produce.
  function automatic queue_report_t decode_request(logic [OP_W-1:0] op,
                                                   logic [ENC_W-1:0] enc,
                                                   logic [AB_W-1:0] ab,
                                                   logic [TICK_W-1:0] tick);
    queue_report_t  rep;
    logic [AB_W-1:0] was;
    int step;
    int span;
    int total;
    int detents;
    int slot;
    rep = '0;
    case (op)
      OP_SAMPLE: begin
        was = last_ab[enc];
        last_ab[enc] = ab;
        // An unchanged state and a two-bit jump both decode to no step.
        step = (ab == cw_next(was)) ? 1 : (ab == ccw_next(was)) ? -1 : 0;
        if (rev_reg) begin
          step = -step;
        end
        span = (detent_reg < 1) ? 1 : (detent_reg > 4) ? 4 : int'(detent_reg);
        if (step != 0) begin
          // Division truncates toward zero; the signed remainder stays with the encoder.
          total = residual[enc] + step;
          detents = total / span;
          residual[enc] = total % span;
          repeat ((detents < 0) ? -detents : detents) begin
            // The serial skips zero and advances even for an event that is dropped.
            serial_ctr = serial_ctr + 1'b1;
            if (serial_ctr == '0) begin
              serial_ctr = 1;
            end
            if (queued_events() >= QUEUE_DEPTH) begin
              drop_ctr = drop_ctr + 1'b1;
            end else begin
              slot = wr_ptr % QUEUE_DEPTH;
              slot_enc[slot] = enc;
              slot_neg[slot] = (detents < 0);
              slot_tick[slot] = tick;
              slot_serial[slot] = serial_ctr;
              wr_ptr = (wr_ptr + 1) % (2 * QUEUE_DEPTH);
            end
          end
        end
      end
      OP_POP: begin
        if (rd_ptr != wr_ptr) begin
          slot = rd_ptr % QUEUE_DEPTH;
          rep.valid = 1'b1;
          rep.enc = slot_enc[slot];
          rep.dir = slot_neg[slot] ? DIR_NEG : DIR_POS;
          rep.tick = slot_tick[slot];
          rep.serial = slot_serial[slot];
          rd_ptr = (rd_ptr + 1) % (2 * QUEUE_DEPTH);
        end
      end
      OP_DISCARD: begin
        // Empties the queue and forgets partial detents; serial and drop count survive.
        rd_ptr = wr_ptr;
        foreach (residual[i]) begin
          residual[i] = 0;
        end
      end
      OP_SEED: begin
        last_ab[enc] = ab;
      end
    endcase
    rep.pending = PEND_W'(queued_events());
    rep.overflow = drop_ctr;
    return rep;
  endfunction

  function automatic stim_row_t req_row(logic [OP_W-1:0] op, logic [ENC_W-1:0] enc,
                                        logic [AB_W-1:0] ab, logic [TICK_W-1:0] tick,
                                        bit typed = 1'b0, queue_report_t want = '0);
    stim_row_t row;
    row.kind = typed ? ROW_TYPED : ROW_REQUEST;
    row.op = op;
    row.enc = enc;
    row.ab = ab;
    row.tick = tick;
    row.want = want;
    row.reg_index = REG_TPD;
    row.reg_value = '0;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [TPD_W-1:0] value);
    stim_row_t row;
    row = req_row(OP_SAMPLE, '0, '0, '0);
    row.kind = ROW_REGISTER;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  // Lowers s_tvalid once, and only if it is up, so one time step never sees two NBAs on it.
  task automatic stop_requests();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offers one request after a random idle and records its report once it is accepted.
  // A typed row's written-out report replaces the computed one, while the shadow still advances.
  task automatic send_request(logic [OP_W-1:0] op, logic [ENC_W-1:0] enc, logic [AB_W-1:0] ab,
                              logic [TICK_W-1:0] tick, bit typed, queue_report_t want);
    int gap;
    queue_report_t rep;
    gap = $urandom_range(gap_max_s);
    if (gap > 0) begin
      stop_requests();
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    offering = 1'b1;
    s_tdata <= S_TDATA_W'({tick, ab, enc});
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    rep = decode_request(op, enc, ab, tick);
    owed_reports.push_back(typed ? want : rep);
    n_requests++;
  endtask

  task automatic wait_all_reports();
    stop_requests();
    while (owed_reports.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the block idle: every report in, then a short settle.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [TPD_W-1:0] value);
    wait_all_reports();
    repeat (DRAIN_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TPD) begin
      detent_reg = value;
    end else begin
      rev_reg = value[0];
    end
    n_reg_writes++;
  endtask

  // Report sink: idles at random, takes one long back-pressure stretch when asked, and checks
  // every accepted report against the oldest one owed.
  initial begin : report_sink
    int gap;
    string fields;
    queue_report_t got;
    queue_report_t want;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = hold_reports ? LONG_HOLD : $urandom_range(gap_max_m);
      hold_reports = 1'b0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.valid = m_tuser;
      got.enc = m_tdata[2:0];
      got.dir = m_tdata[4:3];
      got.tick = m_tdata[36:5];
      got.serial = m_tdata[68:37];
      got.pending = m_tdata[73:69];
      got.overflow = m_tdata[105:74];
      n_reports++;
      if (got.valid === 1'b1) begin
        n_events++;
      end
      if (owed_reports.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) begin
          $display("[%0t] report %0d arrived with no request waiting for it", $realtime,
                   n_reports);
        end
      end else begin
        want = owed_reports.pop_front();
        fields = "";
        if (got.valid !== want.valid) fields = {fields, " valid"};
        if (got.enc !== want.enc) fields = {fields, " encoder"};
        if (got.dir !== want.dir) fields = {fields, " direction"};
        if (got.tick !== want.tick) fields = {fields, " tick"};
        if (got.serial !== want.serial) fields = {fields, " serial"};
        if (got.pending !== want.pending) fields = {fields, " pending"};
        if (got.overflow !== want.overflow) fields = {fields, " overflow"};
        if (fields != "") begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("[%0t] report %0d differs in%s", $realtime, n_reports, fields);
            $display("  expected v=%0b enc=%0d dir=%b tick=%h serial=%h pend=%0d ovf=%0d",
                     want.valid, want.enc, want.dir, want.tick, want.serial, want.pending,
                     want.overflow);
            $display("  actual   v=%0b enc=%0d dir=%b tick=%h serial=%h pend=%0d ovf=%0d",
                     got.valid, got.enc, got.dir, got.tick, got.serial, got.pending,
                     got.overflow);
          end
        end
      end
    end
  end

  // Watchdog: any accepted request, report or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer on any channel for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t rows [$];
    bit lean [NUM_ENCODERS];
    logic [OP_W-1:0] op;
    logic [ENC_W-1:0] enc;
    logic [AB_W-1:0] ab;
    int pick;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= OP_SAMPLE;
    cfg_valid <= 1'b0;
    cfg_index <= REG_TPD;
    cfg_data <= '0;
    quiet_cycles = 0;
    offering = 1'b0;
    hold_reports = 1'b0;
    gap_max_s = GAP_MAX;
    gap_max_m = GAP_MAX;
    n_requests = 0;
    n_reports = 0;
    n_events = 0;
    n_reg_writes = 0;
    n_mismatch = 0;
    // Shadow state after reset: detent size 4, forward direction, everything else cleared.
    detent_reg = TPD_RESET;
    rev_reg = 1'b0;
    foreach (last_ab[i]) begin
      last_ab[i] = '0;
      residual[i] = 0;
    end
    wr_ptr = 0;
    rd_ptr = 0;
    serial_ctr = '0;
    drop_ctr = '0;
    enc = '0;

    // Directed table. Reports are written out where they are obvious: right after reset,
    // no-op requests, and pops of events whose fields were set just before.
    rows.push_back(req_row(OP_POP, 3'd0, 2'd0, 32'h0, 1'b1, '0));        // pop on empty queue
    rows.push_back(req_row(OP_DISCARD, 3'd0, 2'd0, 32'h0, 1'b1, '0));    // discard with nothing
    rows.push_back(req_row(OP_SAMPLE, 3'd0, 2'd0, 32'h0, 1'b1, '0));     // unchanged pins
    rows.push_back(req_row(OP_SEED, 3'd7, 2'd3, 32'h0, 1'b1, '0));       // seed top encoder
    rows.push_back(req_row(OP_SAMPLE, 3'd7, 2'd3, 32'hFFFF_FFFF, 1'b1, '0));
    // One full forward detent on encoder 0, the last transition stamped with the top tick.
    rows.push_back(req_row(OP_SAMPLE, 3'd0, 2'd2, 32'h0000_0001));
    rows.push_back(req_row(OP_SAMPLE, 3'd0, 2'd3, 32'h8000_0000));
    rows.push_back(req_row(OP_SAMPLE, 3'd0, 2'd1, 32'h5555_5555));
    rows.push_back(req_row(OP_SAMPLE, 3'd0, 2'd0, 32'hFFFF_FFFF));
    rows.push_back(req_row(OP_POP, 3'd0, 2'd0, 32'h0, 1'b1,
                           '{1'b1, 3'd0, DIR_POS, 32'hFFFF_FFFF, 32'd1, 5'd0, 32'd0}));
    // A two-bit jump moves the pins without a step; the next quarter turn leaves a residual
    // that the discard then clears.
    rows.push_back(req_row(OP_SAMPLE, 3'd1, 2'd3, 32'hAAAA_AAAA));
    rows.push_back(req_row(OP_SAMPLE, 3'd1, 2'd1, 32'h1234_5678));
    rows.push_back(req_row(OP_DISCARD, 3'd1, 2'd0, 32'h0));
    // One transition per detent with the direction reversed: a forward step reads backward.
    rows.push_back(reg_row(REG_TPD, 3'd1));
    rows.push_back(reg_row(REG_REV, 3'd1));
    rows.push_back(req_row(OP_SAMPLE, 3'd7, 2'd1, 32'h0));
    rows.push_back(req_row(OP_POP, 3'd0, 2'd0, 32'h0, 1'b1,
                           '{1'b1, 3'd7, DIR_NEG, 32'h0, 32'd2, 5'd0, 32'd0}));
    // Detent size 7 acts as 4 and direction 2 as forward. Three quarter turns stay in the
    // residual; size 0 (acting as 1) then lets the fourth complete four detents at once.
    rows.push_back(reg_row(REG_TPD, 3'd7));
    rows.push_back(reg_row(REG_REV, 3'd2));
    rows.push_back(req_row(OP_SAMPLE, 3'd2, 2'd2, 32'h0F0F_0F0F));
    rows.push_back(req_row(OP_SAMPLE, 3'd2, 2'd3, 32'hF0F0_F0F0));
    rows.push_back(req_row(OP_SAMPLE, 3'd2, 2'd1, 32'h3C3C_3C3C));
    rows.push_back(reg_row(REG_TPD, 3'd0));
    rows.push_back(req_row(OP_SAMPLE, 3'd2, 2'd0, 32'hC3C3_C3C3));
    rows.push_back(req_row(OP_POP, 3'd0, 2'd0, 32'h0));
    rows.push_back(req_row(OP_POP, 3'd0, 2'd0, 32'h0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGISTER) begin
        write_register(rows[i].reg_index, rows[i].reg_value);
      end else begin
        send_request(rows[i].op, rows[i].enc, rows[i].ab, rows[i].tick,
                     rows[i].kind == ROW_TYPED, rows[i].want);
      end
    end

    // Random phases. Samples mostly walk the Gray code, each encoder leaning one way per phase
    // so that whole detents keep coming; unchanged pins and jumps are mixed in. A low pop share
    // fills the queue and drives it into overflow, a high one drains it.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_register(REG_TPD, TPD_W'(phase_tpd[phase]));
      write_register(REG_REV, TPD_W'(phase_rev[phase]));
      gap_max_s = phase_s_gap[phase] ? GAP_MAX : 0;
      gap_max_m = phase_m_gap[phase] ? GAP_MAX : 0;
      foreach (lean[e]) begin
        lean[e] = 1'($urandom_range(1));
      end
      // The receiver stalls for a long stretch while requests keep coming, so the block backs
      // up and stops taking requests.
      if (phase == 0 || phase == 6) begin
        hold_reports = 1'b1;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Once, the sender goes quiet until every owed report has come back.
        if (phase == 2 && k == PHASE_ITEMS / 2) begin
          wait_all_reports();
        end
        pick = $urandom_range(99);
        if (pick < phase_pop[phase]) begin
          op = OP_POP;
        end else if (pick < phase_pop[phase] + 3) begin
          op = OP_DISCARD;
        end else if (pick < phase_pop[phase] + 6) begin
          op = OP_SEED;
        end else begin
          op = OP_SAMPLE;
        end
        if ($urandom_range(1)) begin
          enc = ENC_W'($urandom_range(NUM_ENCODERS - 1));
        end
        ab = AB_W'($urandom_range(3));
        if (op == OP_SAMPLE) begin
          pick = $urandom_range(99);
          if (pick < 6) begin
            ab = last_ab[enc];
          end else if (pick < 12) begin
            ab = last_ab[enc] ^ 2'b11;
          end else if ((pick < 88) == lean[enc]) begin
            ab = cw_next(last_ab[enc]);
          end else begin
            ab = ccw_next(last_ab[enc]);
          end
        end
        send_request(op, enc, ab, $urandom, 1'b0, '0);
      end
    end

    wait_all_reports();
    repeat (3 * DRAIN_SETTLE) @(posedge clk);
    $display("Sent %0d requests over %0d register settings; %0d reports checked, %0d mismatched.",
             n_requests, n_reg_writes, n_reports, n_mismatch);
    $display("Popped %0d events; serial reached %0d and %0d events were dropped on a full queue.",
             n_events, serial_ctr, drop_ctr);
    if (n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[quadrature_detent_event_queue.f]
+incdir+hw/rtl
hw/rtl/qdeq_pkg.sv
hw/rtl/qdeq_ram.sv
hw/rtl/qdeq_step.sv
hw/rtl/quadrature_detent_event_queue.sv
tb/sv/testbench.sv
